### hw/rtl/lcdfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdfb_pkg
// Item codes, draw modes, controller states and field widths for the
// blinking LCD frame buffer.
// ----------------------------------------------------------------------------
package lcdfb_pkg;

    localparam int KIND_W  = 3;
    localparam int COL_W   = 4;
    localparam int ROW_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 3;
    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] REVERSE_PHASE_RESET = 3'd6;
    localparam logic [BYTE_W-1:0]  BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0]  BYTE_ONES = 8'hFF;
    localparam logic [BYTE_W-1:0]  LOCK_MAX  = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_DRAW   = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_READ   = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_FILL   = 3'd4,
        KIND_LOCK   = 3'd5,
        KIND_UNLOCK = 3'd6,
        KIND_NOP    = 3'd7
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL     = 3'd0,
        MODE_REVERSE    = 3'd1,
        MODE_FG_BLINK   = 3'd2,
        MODE_BG_BLINK   = 3'd3,
        MODE_NORM_BLINK = 3'd4,
        MODE_REV_BLINK  = 3'd5,
        MODE_ALT_NORM_A = 3'd6,
        MODE_ALT_NORM_B = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_SWEEP,
        ST_XOR,
        ST_XOR_TAIL
    } state_t;

endpackage : lcdfb_pkg
`default_nettype wire

### hw/rtl/blinking_lcd_frame_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blinking_lcd_frame_buffer
// Byte-wide LCD pixel buffer with a blink-mask buffer, masked draws and
// phase-driven blink inversion.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result is
// shown for one cycle with done high and cannot be held off by the receiver.
// Lock, unlock, unused kinds, out-of-range draws and reads, and ticks that
// do not invert are answered straight from idle; draws and reads in range
// take one RAM read, then the write or the result; a tick that inverts
// walks both RAMs one entry a cycle, reading one entry while writing the
// previous one back into the pixel RAM, and then writes back the last
// entry; clear and fill write one entry of both RAMs a cycle. After reset
// the block zeroes both RAMs with busy high. The reverse_phase register is
// written through cfg_valid/cfg_ready, which is always ready.
// ----------------------------------------------------------------------------
module blinking_lcd_frame_buffer #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [lcdfb_pkg::KIND_W-1:0]          kind,
    input  wire logic [lcdfb_pkg::COL_W-1:0]           column,
    input  wire logic [lcdfb_pkg::ROW_W-1:0]           row,
    input  wire logic [lcdfb_pkg::BYTE_W-1:0]          pattern,
    input  wire logic [lcdfb_pkg::BYTE_W-1:0]          mask,
    input  wire logic [lcdfb_pkg::MODE_W-1:0]          draw_mode,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lcdfb_pkg::PHASE_W-1:0]         cfg_data,
    output logic                                       done,
    output logic      [lcdfb_pkg::BYTE_W-1:0]          data_byte,
    output logic      [lcdfb_pkg::BYTE_W-1:0]          blink_byte,
    output logic                                       refresh,
    output logic                                       reversed,
    output logic      [lcdfb_pkg::BYTE_W-1:0]          lock_count
);

    import lcdfb_pkg::*;

    localparam int DEPTH = COLUMNS * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // control state
    state_t              state_reg,     state_next;
    logic [AW-1:0]       sweep_reg,     sweep_next;
    logic                pend_reg,      pend_next;
    logic [PHASE_W-1:0]  phase_reg,     phase_next;
    logic                target_reg,    target_next;
    logic                is_rev_reg,    is_rev_next;
    logic [BYTE_W-1:0]   locks_reg,     locks_next;
    logic [CNT_W-1:0]    nz_cnt_reg,    nz_cnt_next;
    logic [PHASE_W-1:0]  rev_phase_reg;
    logic                done_reg,      done_next;

    // payload
    logic [AW-1:0]       pos_reg,       pos_next;
    logic [AW-1:0]       prev_reg,      prev_next;
    logic [BYTE_W-1:0]   pat_reg,       pat_next;
    logic [BYTE_W-1:0]   msk_reg,       msk_next;
    logic [MODE_W-1:0]   mode_reg,      mode_next;
    logic [BYTE_W-1:0]   fill_reg,      fill_next;
    logic [BYTE_W-1:0]   dbyte_reg,     dbyte_next;
    logic [BYTE_W-1:0]   bbyte_reg,     bbyte_next;
    logic                refresh_reg,   refresh_next;

    // RAM ports
    logic                pix_we, blk_we;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [BYTE_W-1:0]   pix_wd, blk_wd, pix_rd, blk_rd;

    logic                in_range;
    logic [AW-1:0]       pos_in;
    logic [PHASE_W-1:0]  tick_phase;
    logic                tick_target;
    logic [BYTE_W-1:0]   d_norm, d_rev, d_new, b_new;

    lcdfb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_pixel_ram (
        .clk     (clk),
        .we      (pix_we),
        .wr_addr (wr_addr),
        .wr_data (pix_wd),
        .rd_addr (rd_addr),
        .rd_data (pix_rd)
    );

    lcdfb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_blink_ram (
        .clk     (clk),
        .we      (blk_we),
        .wr_addr (wr_addr),
        .wr_data (blk_wd),
        .rd_addr (rd_addr),
        .rd_data (blk_rd)
    );

    assign in_range = (32'(column) < COLUMNS) && (32'(row) < ROWS);
    assign pos_in   = in_range ? AW'(32'(row) * COLUMNS + 32'(column)) : '0;

    assign tick_phase  = phase_reg + PHASE_W'(1);
    assign tick_target = (tick_phase == '0)            ? 1'b0 :
                         (tick_phase == rev_phase_reg) ? 1'b1 : target_reg;

    // draw merge on the byte just read
    assign d_norm = (pix_rd & ~msk_reg) | pat_reg;
    assign d_rev  = (pix_rd | msk_reg) ^ pat_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_REVERSE:
            begin
                d_new = d_rev;
                b_new = blk_rd & ~msk_reg;
            end
            MODE_FG_BLINK:
            begin
                d_new = is_rev_reg ? (pix_rd & ~msk_reg) : d_norm;
                b_new = (blk_rd & ~msk_reg) | pat_reg;
            end
            MODE_BG_BLINK:
            begin
                d_new = is_rev_reg ? (pix_rd | msk_reg) : d_norm;
                b_new = (blk_rd | msk_reg) ^ pat_reg;
            end
            MODE_NORM_BLINK:
            begin
                d_new = is_rev_reg ? d_rev : d_norm;
                b_new = blk_rd | msk_reg;
            end
            MODE_REV_BLINK:
            begin
                d_new = is_rev_reg ? d_norm : d_rev;
                b_new = blk_rd | msk_reg;
            end
            default:
            begin
                d_new = d_norm;
                b_new = blk_rd & ~msk_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        pend_next    = pend_reg;
        phase_next   = phase_reg;
        target_next  = target_reg;
        is_rev_next  = is_rev_reg;
        locks_next   = locks_reg;
        nz_cnt_next  = nz_cnt_reg;
        done_next    = 1'b0;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        pat_next     = pat_reg;
        msk_next     = msk_reg;
        mode_next    = mode_reg;
        fill_next    = fill_reg;
        dbyte_next   = BYTE_ZERO;
        bbyte_next   = BYTE_ZERO;
        refresh_next = 1'b0;
        pix_we       = 1'b0;
        blk_we       = 1'b0;
        rd_addr      = pos_in;
        wr_addr      = sweep_reg;
        pix_wd       = fill_reg;
        blk_wd       = BYTE_ZERO;

        case (state_reg)
            ST_INIT:
            begin
                pix_we     = 1'b1;
                blk_we     = 1'b1;
                pix_wd     = BYTE_ZERO;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    pos_next  = pos_in;
                    pat_next  = pattern;
                    msk_next  = mask;
                    mode_next = draw_mode;
                    case (kind)
                        KIND_DRAW:
                        begin
                            if (in_range)
                                state_next = ST_DRAW;
                            else
                                done_next = 1'b1;
                        end
                        KIND_TICK:
                        begin
                            phase_next  = tick_phase;
                            target_next = tick_target;
                            if (locks_reg == BYTE_ZERO && tick_target != is_rev_reg &&
                                nz_cnt_reg != '0)
                            begin
                                is_rev_next = tick_target;
                                sweep_next  = '0;
                                pend_next   = 1'b0;
                                state_next  = ST_XOR;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            if (in_range)
                                state_next = ST_READ;
                            else
                                done_next = 1'b1;
                        end
                        KIND_CLEAR, KIND_FILL:
                        begin
                            fill_next   = (kind == KIND_FILL) ? BYTE_ONES : BYTE_ZERO;
                            nz_cnt_next = '0;
                            sweep_next  = '0;
                            state_next  = ST_SWEEP;
                        end
                        KIND_LOCK:
                        begin
                            if (locks_reg != LOCK_MAX)
                                locks_next = locks_reg + BYTE_W'(1);
                            done_next = 1'b1;
                        end
                        KIND_UNLOCK:
                        begin
                            if (locks_reg != BYTE_ZERO)
                                locks_next = locks_reg - BYTE_W'(1);
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                pix_we  = 1'b1;
                blk_we  = 1'b1;
                wr_addr = pos_reg;
                pix_wd  = d_new;
                blk_wd  = b_new;
                // track how many blink bytes are nonzero
                nz_cnt_next = nz_cnt_reg
                            - CNT_W'(blk_rd != BYTE_ZERO)
                            + CNT_W'(b_new != BYTE_ZERO);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                dbyte_next = pix_rd;
                bbyte_next = blk_rd;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                pix_we     = 1'b1;
                blk_we     = 1'b1;
                pix_wd     = fill_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_XOR:
            begin
                // read entry sweep, write back entry read last cycle
                rd_addr    = sweep_reg;
                wr_addr    = prev_reg;
                pix_we     = pend_reg;
                pix_wd     = pix_rd ^ blk_rd;
                prev_next  = sweep_reg;
                pend_next  = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_XOR_TAIL;
                end
            end
            ST_XOR_TAIL:
            begin
                wr_addr      = prev_reg;
                pix_we       = 1'b1;
                pix_wd       = pix_rd ^ blk_rd;
                pend_next    = 1'b0;
                refresh_next = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            phase_reg     <= '0;
            target_reg    <= 1'b0;
            is_rev_reg    <= 1'b0;
            locks_reg     <= BYTE_ZERO;
            nz_cnt_reg    <= '0;
            rev_phase_reg <= REVERSE_PHASE_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            pend_reg   <= pend_next;
            phase_reg  <= phase_next;
            target_reg <= target_next;
            is_rev_reg <= is_rev_next;
            locks_reg  <= locks_next;
            nz_cnt_reg <= nz_cnt_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                rev_phase_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        prev_reg    <= prev_next;
        pat_reg     <= pat_next;
        msk_reg     <= msk_next;
        mode_reg    <= mode_next;
        fill_reg    <= fill_next;
        dbyte_reg   <= dbyte_next;
        bbyte_reg   <= bbyte_next;
        refresh_reg <= refresh_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign data_byte  = dbyte_reg;
    assign blink_byte = bbyte_reg;
    assign refresh    = refresh_reg;
    assign reversed   = is_rev_reg;
    assign lock_count = locks_reg;

endmodule : blinking_lcd_frame_buffer
`default_nettype wire

### hw/rtl/lcdfb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdfb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lcdfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : lcdfb_ram
`default_nettype wire
